@@ rtl/rsk_pkg.sv @@
`timescale 1ns / 1ps

package rsk_pkg;

    localparam int KEY_W          = 31;
    localparam int IDX_W          = 16;
    localparam int PAIR_W         = KEY_W + IDX_W;
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int DIGIT_BITS_DEF = 8;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHK,
        S_CLR,
        S_HIST_RD,
        S_HIST_CNT,
        S_HIST_WR,
        S_PFX,
        S_SC_RD,
        S_SC_CNT,
        S_SC_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic bin_clr;
        logic clr_step;
        logic idx_clr;
        logic idx_fill;
        logic hist_rd;
        logic cnt_rd;
        logic hist_wr;
        logic pfx_step;
        logic sc_rd;
        logic sc_wr;
        logic pass_end;
        logic out_rd;
        logic out_ld;
        logic set_done;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic idx_zero;
        logic bin_last;
        logic bin_end;
        logic rem_zero;
        logic out_last;
    } t_status;

endpackage

@@ rtl/radix_sort_key_index.sv @@
// loading: transfers are taken back to back, no results until the transfer flagged last_in
// sorting: one pass per digit of the largest key: check, count clear sweep, histogram
//   read-modify-write per pair, prefix sweep, scatter read-modify-write per pair
// output: after the passes each result is read, loaded and held valid until taken;
//   input is stalled from set close to last result
// reset: synchronous active low, returns to loading with an empty set, one set at a time
`timescale 1ns / 1ps

module radix_sort_key_index #(
    parameter int MAX_ITEMS  = rsk_pkg::MAX_ITEMS_DEF,
    parameter int DIGIT_BITS = rsk_pkg::DIGIT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [rsk_pkg::KEY_W-1:0] i_key,
    input  logic [rsk_pkg::IDX_W-1:0] i_payload_index,
    input  logic                      i_last_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [rsk_pkg::KEY_W-1:0] o_sorted_key,
    output logic [rsk_pkg::IDX_W-1:0] o_sorted_index,
    output logic                      o_last_out
);

    rsk_pkg::t_cmd    cmd;
    rsk_pkg::t_status status;

    rsk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_in   (i_last_in),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rsk_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_key           (i_key),
        .i_payload_index (i_payload_index),
        .o_sorted_key    (o_sorted_key),
        .o_sorted_index  (o_sorted_index),
        .o_last_out      (o_last_out)
    );

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while results pending");

    // closing transfer stops further input
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_in |=> o_in_stall)
        else $error("input not stalled after set close");

    // final result reopens the input
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_out |=> !o_in_stall && !o_out_valid)
        else $error("input not reopened after final result");

    // a non-final result is followed by another one
    a_more_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_out |=> ##1 o_out_valid)
        else $error("result sequence broken");

endmodule

@@ rtl/rsk_ram.sv @@
`timescale 1ns / 1ps

module rsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rsk_datapath.sv @@
`timescale 1ns / 1ps

module rsk_datapath #(
    parameter int MAX_ITEMS  = rsk_pkg::MAX_ITEMS_DEF,
    parameter int DIGIT_BITS = rsk_pkg::DIGIT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rsk_pkg::t_cmd            i_cmd,
    output rsk_pkg::t_status         o_status,
    input  logic [rsk_pkg::KEY_W-1:0] i_key,
    input  logic [rsk_pkg::IDX_W-1:0] i_payload_index,
    output logic [rsk_pkg::KEY_W-1:0] o_sorted_key,
    output logic [rsk_pkg::IDX_W-1:0] o_sorted_index,
    output logic                     o_last_out
);

    localparam int KEY_W   = rsk_pkg::KEY_W;
    localparam int IDX_W   = rsk_pkg::IDX_W;
    localparam int PAIR_W  = rsk_pkg::PAIR_W;
    localparam int AW      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int BINS    = 1 << DIGIT_BITS;
    localparam int BIN_CW  = DIGIT_BITS + 1;
    localparam int SHIFT_W = $clog2(KEY_W + DIGIT_BITS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_idx;
    logic [KEY_W-1:0]      r_rem;
    logic [SHIFT_W-1:0]    r_shift;
    logic                  r_src;
    logic [BIN_CW-1:0]     r_bin;
    logic [CNT_W-1:0]      r_sum;
    logic [KEY_W-1:0]      r_out_key;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_last;

    logic                  fits;
    logic [PAIR_W-1:0]     b0_rdata;
    logic [PAIR_W-1:0]     b1_rdata;
    logic [PAIR_W-1:0]     src_data;
    logic [KEY_W-1:0]      src_key;
    logic [KEY_W-1:0]      shifted;
    logic [DIGIT_BITS-1:0] digit;
    logic [CNT_W-1:0]      cnt_rdata;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      pfx_sum;
    logic [BIN_CW-1:0]     bin_prev;
    logic [CNT_W-1:0]      idx_prev;

    logic                  src_re;
    logic [AW-1:0]         src_raddr;
    logic                  b0_we;
    logic                  b1_we;
    logic [AW-1:0]         d_waddr;
    logic [PAIR_W-1:0]     d_wdata;

    logic                  c_we;
    logic [DIGIT_BITS-1:0] c_waddr;
    logic [CNT_W-1:0]      c_wdata;
    logic                  c_re;
    logic [DIGIT_BITS-1:0] c_raddr;

    assign fits     = r_cnt < CNT_W'(MAX_ITEMS);
    assign src_data = r_src ? b1_rdata : b0_rdata;
    assign src_key  = src_data[PAIR_W-1 -: KEY_W];
    assign shifted  = src_key >> r_shift;
    assign digit    = shifted[DIGIT_BITS-1:0];
    assign pos      = cnt_rdata - CNT_W'(1);
    assign pfx_sum  = r_sum + cnt_rdata;
    assign bin_prev = r_bin - BIN_CW'(1);
    assign idx_prev = r_idx - CNT_W'(1);

    // pair banks, ping-pong between passes
    assign src_re    = i_cmd.hist_rd | i_cmd.sc_rd | i_cmd.out_rd;
    assign src_raddr = i_cmd.sc_rd ? idx_prev[AW-1:0] : r_idx[AW-1:0];
    assign b0_we     = (i_cmd.load & fits & ~r_src) | (i_cmd.sc_wr & r_src);
    assign b1_we     = (i_cmd.load & fits & r_src) | (i_cmd.sc_wr & ~r_src);
    assign d_waddr   = i_cmd.load ? r_cnt[AW-1:0] : pos[AW-1:0];
    assign d_wdata   = i_cmd.load ? {i_key, i_payload_index} : src_data;

    // bin counts
    always_comb begin
        c_we    = 1'b0;
        c_waddr = digit;
        c_wdata = '0;
        c_re    = 1'b0;
        c_raddr = digit;
        if (i_cmd.clr_step) begin
            c_we    = 1'b1;
            c_waddr = r_bin[DIGIT_BITS-1:0];
        end
        if (i_cmd.hist_wr) begin
            c_we    = 1'b1;
            c_wdata = cnt_rdata + CNT_W'(1);
        end
        if (i_cmd.sc_wr) begin
            c_we    = 1'b1;
            c_wdata = pos;
        end
        if (i_cmd.cnt_rd) begin
            c_re = 1'b1;
        end
        if (i_cmd.pfx_step) begin
            c_re    = ~o_status.bin_end;
            c_raddr = r_bin[DIGIT_BITS-1:0];
            c_we    = (r_bin != '0);
            c_waddr = bin_prev[DIGIT_BITS-1:0];
            c_wdata = pfx_sum;
        end
    end

    rsk_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (b0_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (src_re),
        .i_raddr (src_raddr),
        .o_rdata (b0_rdata)
    );

    rsk_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (b1_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (src_re),
        .i_raddr (src_raddr),
        .o_rdata (b1_rdata)
    );

    rsk_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_counts (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_rem   <= '0;
            r_shift <= '0;
            r_src   <= 1'b0;
            r_bin   <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.load && fits) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (i_key > r_rem) begin
                    r_rem <= i_key;
                end
            end
            if (i_cmd.bin_clr) begin
                r_bin <= '0;
                r_sum <= '0;
            end
            if (i_cmd.clr_step) begin
                r_bin <= r_bin + BIN_CW'(1);
            end
            if (i_cmd.pfx_step) begin
                r_bin <= r_bin + BIN_CW'(1);
                if (r_bin != '0) begin
                    r_sum <= pfx_sum;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end
            if (i_cmd.idx_fill) begin
                r_idx <= r_cnt;
            end
            if (i_cmd.hist_wr || i_cmd.out_ld) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.sc_rd) begin
                r_idx <= idx_prev;
            end
            if (i_cmd.pass_end) begin
                r_src   <= ~r_src;
                r_rem   <= r_rem >> DIGIT_BITS;
                r_shift <= r_shift + SHIFT_W'(DIGIT_BITS);
            end
            if (i_cmd.set_done) begin
                r_cnt   <= '0;
                r_rem   <= '0;
                r_shift <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_key  <= src_key;
            r_out_idx  <= src_data[IDX_W-1:0];
            r_out_last <= (r_idx + CNT_W'(1)) == r_cnt;
        end
    end

    assign o_status.idx_end  = (r_idx == r_cnt);
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.bin_last = (r_bin == BIN_CW'(BINS - 1));
    assign o_status.bin_end  = (r_bin == BIN_CW'(BINS));
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.out_last = r_out_last;

    assign o_sorted_key   = r_out_key;
    assign o_sorted_index = r_out_idx;
    assign o_last_out     = r_out_last;

endmodule

@@ rtl/rsk_ctrl.sv @@
`timescale 1ns / 1ps

module rsk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_in,
    input  logic             i_out_stall,
    input  rsk_pkg::t_status i_status,
    output rsk_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    rsk_pkg::t_state r_state;
    rsk_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsk_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rsk_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) begin
                        n_state = rsk_pkg::S_CHK;
                    end
                end
            end
            rsk_pkg::S_CHK: begin
                if (i_status.rem_zero) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = rsk_pkg::S_OUT_RD;
                end else begin
                    o_cmd.bin_clr = 1'b1;
                    n_state       = rsk_pkg::S_CLR;
                end
            end
            rsk_pkg::S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.bin_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = rsk_pkg::S_HIST_RD;
                end
            end
            rsk_pkg::S_HIST_RD: begin
                if (i_status.idx_end) begin
                    o_cmd.bin_clr = 1'b1;
                    n_state       = rsk_pkg::S_PFX;
                end else begin
                    o_cmd.hist_rd = 1'b1;
                    n_state       = rsk_pkg::S_HIST_CNT;
                end
            end
            rsk_pkg::S_HIST_CNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = rsk_pkg::S_HIST_WR;
            end
            rsk_pkg::S_HIST_WR: begin
                o_cmd.hist_wr = 1'b1;
                n_state       = rsk_pkg::S_HIST_RD;
            end
            rsk_pkg::S_PFX: begin
                o_cmd.pfx_step = 1'b1;
                if (i_status.bin_end) begin
                    o_cmd.idx_fill = 1'b1;
                    n_state        = rsk_pkg::S_SC_RD;
                end
            end
            rsk_pkg::S_SC_RD: begin
                if (i_status.idx_zero) begin
                    o_cmd.pass_end = 1'b1;
                    n_state        = rsk_pkg::S_CHK;
                end else begin
                    o_cmd.sc_rd = 1'b1;
                    n_state     = rsk_pkg::S_SC_CNT;
                end
            end
            rsk_pkg::S_SC_CNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = rsk_pkg::S_SC_WR;
            end
            rsk_pkg::S_SC_WR: begin
                o_cmd.sc_wr = 1'b1;
                n_state     = rsk_pkg::S_SC_RD;
            end
            rsk_pkg::S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = rsk_pkg::S_OUT_LD;
            end
            rsk_pkg::S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = rsk_pkg::S_OUT_WAIT;
            end
            rsk_pkg::S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    if (i_status.out_last) begin
                        o_cmd.set_done = 1'b1;
                        n_state        = rsk_pkg::S_LOAD;
                    end else begin
                        o_cmd.out_rd = 1'b1;
                        n_state      = rsk_pkg::S_OUT_LD;
                    end
                end
            end
            default: begin
                n_state = rsk_pkg::S_LOAD;
            end
        endcase
    end

    assign o_in_stall  = (r_state != rsk_pkg::S_LOAD);
    assign o_out_valid = (r_state == rsk_pkg::S_OUT_WAIT);

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef logic [rsk_pkg::KEY_W-1:0] key_t;
    typedef logic [rsk_pkg::IDX_W-1:0] idx_t;

    localparam int SET_DEPTH = rsk_pkg::MAX_ITEMS_DEF;
    localparam int DIGIT_W   = rsk_pkg::DIGIT_BITS_DEF;
    localparam int BIN_NUM   = 1 << DIGIT_W;
    localparam int BIN_MASK  = BIN_NUM - 1;
    localparam int RAND_ITEMS = 200;
    localparam int TAIL_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;

    class key_order_board;
        key_t held_keys[SET_DEPTH];
        idx_t held_idx[SET_DEPTH];
        int   held_count;
        key_t peak_key;
        key_t due_keys[$];
        idx_t due_idx[$];
        bit   due_last[$];
        int   errors;

        function new();
            held_count = 0;
            peak_key   = '0;
            errors     = 0;
        endfunction

        function int pending();
            return due_keys.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // one stable counting sort on the digit at this shift
        function void radix_pass(int shift);
            int   bin_tally[BIN_NUM];
            key_t spare_keys[SET_DEPTH];
            idx_t spare_idx[SET_DEPTH];
            int   d;
            for (int b = 0; b < BIN_NUM; b++) begin
                bin_tally[b] = 0;
            end
            for (int i = 0; i < held_count; i++) begin
                d = int'((held_keys[i] >> shift) & BIN_MASK);
                bin_tally[d]++;
            end
            for (int b = 1; b < BIN_NUM; b++) begin
                bin_tally[b] += bin_tally[b - 1];
            end
            for (int i = held_count - 1; i >= 0; i--) begin
                d = int'((held_keys[i] >> shift) & BIN_MASK);
                bin_tally[d]--;
                spare_keys[bin_tally[d]] = held_keys[i];
                spare_idx[bin_tally[d]]  = held_idx[i];
            end
            for (int i = 0; i < held_count; i++) begin
                held_keys[i] = spare_keys[i];
                held_idx[i]  = spare_idx[i];
            end
        endfunction

        function void note_transfer(key_t k, idx_t ix, bit is_last);
            if (held_count < SET_DEPTH) begin
                held_keys[held_count] = k;
                held_idx[held_count]  = ix;
                if (k > peak_key) begin
                    peak_key = k;
                end
                held_count++;
            end
            if (is_last) begin
                for (int s = 0; s < rsk_pkg::KEY_W && (peak_key >> s) != 0; s += DIGIT_W) begin
                    radix_pass(s);
                end
                for (int i = 0; i < held_count; i++) begin
                    due_keys.push_back(held_keys[i]);
                    due_idx.push_back(held_idx[i]);
                    due_last.push_back(i == held_count - 1);
                end
                held_count = 0;
                peak_key   = '0;
            end
        endfunction

        function void check_result(key_t k, idx_t ix, logic is_last);
            key_t ek;
            idx_t ei;
            bit   el;
            if (due_keys.size() == 0) begin
                flag($sformatf("unexpected result key %h index %h last %b", k, ix, is_last));
                return;
            end
            ek = due_keys.pop_front();
            ei = due_idx.pop_front();
            el = due_last.pop_front();
            if (k !== ek) begin
                flag($sformatf("sorted_key expected %h actual %h", ek, k));
            end
            if (ix !== ei) begin
                flag($sformatf("sorted_index expected %h actual %h", ei, ix));
            end
            if (is_last !== el) begin
                flag($sformatf("last_out expected %b actual %b", el, is_last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    key_t in_key = '0;
    idx_t in_index = '0;
    logic in_last = 1'b0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    key_t o_sorted_key;
    idx_t o_sorted_index;
    logic o_last_out;

    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;
    int stall_run = 0;
    int cycle_count = 0;
    int rand_sent = 0;

    key_order_board board = new();

    radix_sort_key_index dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_key           (in_key),
        .i_payload_index (in_index),
        .i_last_in       (in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_sorted_key    (o_sorted_key),
        .o_sorted_index  (o_sorted_index),
        .o_last_out      (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // receiver holds stall steady for runs of random length
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            out_stall <= rx_stalls_on && ($urandom_range(0, 2) == 0);
            stall_run <= pick_gap(1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            board.check_result(o_sorted_key, o_sorted_index, o_last_out);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input key_t k, input idx_t ix, input logic is_last);
        int gap;
        gap = pick_gap(tx_gaps_on);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_key   <= key_t'($urandom);
            in_index <= idx_t'($urandom);
            in_last  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_key   <= k;
        in_index <= ix;
        in_last  <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_transfer(k, ix, is_last);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
    endtask

    task automatic send_set(input int count, input int key_bits, input bit dup_heavy);
        key_t pool[4];
        key_t mask;
        key_t k;
        mask = (key_bits == 0) ? '0 : ({rsk_pkg::KEY_W{1'b1}} >> (rsk_pkg::KEY_W - key_bits));
        for (int p = 0; p < 4; p++) begin
            pool[p] = key_t'($urandom) & mask;
        end
        for (int i = 0; i < count; i++) begin
            k = dup_heavy ? pool[$urandom_range(0, 3)] : (key_t'($urandom) & mask);
            send_item(k, idx_t'($urandom), i == count - 1);
            rand_sent++;
        end
    endtask

    initial begin
        int r;
        int count;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lone zero key closes a set with no pass
        send_item('0, '0, 1'b1);
        // all keys zero keep input order
        send_item('0, 16'hFFFF, 1'b0);
        send_item('0, 16'h0001, 1'b0);
        send_item('0, 16'h0002, 1'b1);
        // extremes, ties and all four digit positions
        send_item(31'h7FFFFFFF, 16'hFFFF, 1'b0);
        send_item(31'h00000000, 16'h0000, 1'b0);
        send_item(31'h7FFFFFFF, 16'h0001, 1'b0);
        send_item(31'h00000100, 16'h0002, 1'b0);
        send_item(31'h000000FF, 16'h0003, 1'b0);
        send_item(31'h40000000, 16'h0004, 1'b0);
        send_item(31'h00FF0000, 16'h0005, 1'b0);
        send_item(31'h00000001, 16'h0006, 1'b1);
        wait_drain();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_item(31'h01000000, 16'h8000, 1'b0);
        send_item(31'h00010000, 16'h4000, 1'b0);
        send_item(31'h00000100, 16'h2000, 1'b0);
        send_item(31'h00000001, 16'h1000, 1'b0);
        send_item(31'h01010101, 16'h0800, 1'b0);
        send_item(31'h01000000, 16'h0400, 1'b1);
        wait_drain();

        // a full set, then one with pairs past the store
        send_set(SET_DEPTH, 31, 1'b0);
        send_set($urandom_range(SET_DEPTH + 1, SET_DEPTH + 3), $urandom_range(1, 31), 1'b1);
        while (rand_sent < RAND_ITEMS) begin
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                count = SET_DEPTH;
            end else if (r < 10) begin
                count = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 3);
            end else begin
                count = $urandom_range(1, 10);
            end
            send_set(count, $urandom_range(0, 31), $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_drain();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() > 0) begin
            board.flag("results still outstanding at end of run");
        end
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
